// File: rtl/pctbl_pkg.sv
// Shared types and constants for the per-client token bucket limiter.
// Holds opcodes, register indexes, table sizing, the FSM state type and control structs.
// No dependencies.
`timescale 1ns / 1ps

package pctbl_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
   localparam int ADDR_W        = 32;
   localparam int MS_PER_S      = 1000;
   localparam int LIMIT_W       = 33;

   localparam logic [2:0] OP_REQUEST = 3'd0;
   localparam logic [2:0] OP_QUERY   = 3'd1;
   localparam logic [2:0] OP_RESET   = 3'd2;
   localparam logic [2:0] OP_CLEANUP = 3'd3;
   localparam logic [2:0] OP_CLEAR   = 3'd4;

   localparam logic CSR_BURST_SIZE = 1'b0;
   localparam logic CSR_REFILL     = 1'b1;

   localparam logic [15:0] BURST_RESET  = 16'd10;
   localparam logic [31:0] REFILL_RESET = 32'd6554;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_DRAIN,
      ST_MUL,
      ST_SUM,
      ST_WRITE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [31:0]       tokens;
      logic [31:0]       refill_ms;
      logic [31:0]       access_ms;
   } entry_type;

   typedef struct packed {
      logic latch;
      logic scan_init;
      logic scan;
      logic mul;
      logic sum;
      logic write;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic need_scan;
      logic mul_path;
      logic scan_last;
      logic rsp_free;
   } status_type;

endpackage

// File: rtl/pctbl_ctrl.sv
// Controller FSM of the token bucket limiter: sequences latch, table scan,
// refill arithmetic, write-back and result transfer. Depends on pctbl_pkg.
`timescale 1ns / 1ps

module pctbl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  pctbl_pkg::status_type status,
   output pctbl_pkg::cmd_type    cmd
);

   pctbl_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pctbl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pctbl_pkg::ST_IDLE: begin
            if (req_valid) state_in = pctbl_pkg::ST_START;
         end
         pctbl_pkg::ST_START: begin
            state_in = status.need_scan ? pctbl_pkg::ST_SCAN : pctbl_pkg::ST_WRITE;
         end
         pctbl_pkg::ST_SCAN: begin
            if (status.scan_last) state_in = pctbl_pkg::ST_DRAIN;
         end
         pctbl_pkg::ST_DRAIN: begin
            state_in = status.mul_path ? pctbl_pkg::ST_MUL : pctbl_pkg::ST_WRITE;
         end
         pctbl_pkg::ST_MUL:   state_in = pctbl_pkg::ST_SUM;
         pctbl_pkg::ST_SUM:   state_in = pctbl_pkg::ST_WRITE;
         pctbl_pkg::ST_WRITE: state_in = pctbl_pkg::ST_RESP;
         pctbl_pkg::ST_RESP: begin
            if (status.rsp_free) state_in = pctbl_pkg::ST_IDLE;
         end
         default: state_in = pctbl_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         pctbl_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.latch = req_valid;
         end
         pctbl_pkg::ST_START: cmd.scan_init = 1'b1;
         pctbl_pkg::ST_SCAN:  cmd.scan = 1'b1;
         pctbl_pkg::ST_DRAIN: ;
         pctbl_pkg::ST_MUL:   cmd.mul = 1'b1;
         pctbl_pkg::ST_SUM:   cmd.sum = 1'b1;
         pctbl_pkg::ST_WRITE: cmd.write = 1'b1;
         pctbl_pkg::ST_RESP:  cmd.load_rsp = status.rsp_free;
         default: ;
      endcase
   end

endmodule

// File: rtl/pctbl_datapath.sv
// Datapath of the token bucket limiter: config registers, bucket table memory,
// valid bits, scan compare, refill multiply and result register. Depends on pctbl_pkg.
`timescale 1ns / 1ps

module pctbl_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic                          csr_index,
   input  logic [31:0]                   csr_write_data,
   input  logic [2:0]                    req_op,
   input  logic [31:0]                   req_client_addr,
   input  logic                          req_addr_present,
   input  logic [15:0]                   req_tokens_wanted,
   input  logic [31:0]                   req_now_ms,
   input  logic [22:0]                   req_idle_limit_s,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_allowed,
   output logic [31:0]                   rsp_remaining_q16,
   output logic [pctbl_pkg::CNT_W-1:0]   rsp_tracked_count,
   output logic                          rsp_table_full,
   input  pctbl_pkg::cmd_type            cmd,
   output pctbl_pkg::status_type         status
);

   localparam int IW = pctbl_pkg::IDX_W;
   localparam int CW = pctbl_pkg::CNT_W;

   logic [15:0] burst_ff;
   logic [31:0] rate_ff;

   logic [2:0]                     op_ff;
   logic [pctbl_pkg::ADDR_W-1:0]   key_ff;
   logic                           present_ff;
   logic [15:0]                    wanted_ff;
   logic [31:0]                    now_ff;
   logic [pctbl_pkg::LIMIT_W-1:0]  limit_ff;

   pctbl_pkg::entry_type mem [pctbl_pkg::TABLE_ENTRIES];
   pctbl_pkg::entry_type rd_ff;
   logic                 wr_en;
   logic [IW-1:0]        wr_idx;
   pctbl_pkg::entry_type wr_rec;

   logic [pctbl_pkg::TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [CW-1:0]                       count_ff, count_in;

   logic [IW-1:0] scan_idx_ff;
   logic          chk_vld_ff;
   logic [IW-1:0] chk_idx_ff;
   logic          hit_ff, free_ff;
   logic [IW-1:0] hit_idx_ff, free_idx_ff;
   logic [31:0]   hit_tok_ff, hit_ref_ff;

   logic [31:0] tok_ff, bal_ff;
   logic [63:0] prod_ff;

   logic        res_allowed_ff, res_full_ff;
   logic [31:0] res_remaining_ff;
   logic        res_allowed_in, res_full_in;
   logic [31:0] res_remaining_in;

   logic        rsp_valid_ff;
   logic        rsp_allowed_ff, rsp_full_ff;
   logic [31:0] rsp_remaining_ff;
   logic [CW-1:0] rsp_count_ff;

   logic [31:0] cap;
   logic        ent_valid, idle_hit, key_hit;
   logic [31:0] idle_elapsed;
   logic [31:0] base_tok, base_ref, mul_elapsed;
   logic [64:0] sum;
   logic [31:0] need;
   logic        grant;

   assign cap = {burst_ff, 16'd0};

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         burst_ff <= pctbl_pkg::BURST_RESET;
         rate_ff  <= pctbl_pkg::REFILL_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            pctbl_pkg::CSR_BURST_SIZE: burst_ff <= csr_write_data[15:0];
            pctbl_pkg::CSR_REFILL:     rate_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // item capture; idle limit turned into milliseconds once
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff      <= req_op;
         key_ff     <= req_client_addr;
         present_ff <= req_addr_present;
         wanted_ff  <= req_tokens_wanted;
         now_ff     <= req_now_ms;
         limit_ff   <= pctbl_pkg::LIMIT_W'(req_idle_limit_s) *
                       pctbl_pkg::LIMIT_W'(pctbl_pkg::MS_PER_S);
      end
   end

   assign status.need_scan = (op_ff == pctbl_pkg::OP_CLEANUP) ||
      (present_ff && (op_ff == pctbl_pkg::OP_REQUEST || op_ff == pctbl_pkg::OP_QUERY ||
                      op_ff == pctbl_pkg::OP_RESET));
   assign status.mul_path = present_ff &&
      (op_ff == pctbl_pkg::OP_REQUEST || op_ff == pctbl_pkg::OP_QUERY);
   assign status.scan_last = (scan_idx_ff == IW'(pctbl_pkg::TABLE_ENTRIES - 1));
   assign status.rsp_free  = !rsp_valid_ff || !rsp_stall;

   // table memory: one registered read, one write
   always_ff @(posedge clock) begin
      rd_ff <= mem[scan_idx_ff];
      if (wr_en) mem[wr_idx] <= wr_rec;
   end

   // scan pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         chk_vld_ff <= 1'b0;
      end else begin
         chk_vld_ff <= cmd.scan;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff <= scan_idx_ff;
      if (cmd.scan_init) begin
         scan_idx_ff <= '0;
      end else if (cmd.scan) begin
         scan_idx_ff <= scan_idx_ff + IW'(1);
      end
   end

   assign ent_valid    = valid_ff[chk_idx_ff];
   assign idle_elapsed = now_ff - rd_ff.access_ms;
   assign idle_hit     = chk_vld_ff && (op_ff == pctbl_pkg::OP_CLEANUP) && ent_valid &&
                         ({1'b0, idle_elapsed} >= limit_ff);
   assign key_hit      = chk_vld_ff && (op_ff != pctbl_pkg::OP_CLEANUP) && ent_valid &&
                         (rd_ff.addr == key_ff);

   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else begin
         if (key_hit && !hit_ff) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= chk_idx_ff;
            hit_tok_ff <= rd_ff.tokens;
            hit_ref_ff <= rd_ff.refill_ms;
         end
         if (chk_vld_ff && !ent_valid && !free_ff) begin
            free_ff     <= 1'b1;
            free_idx_ff <= chk_idx_ff;
         end
      end
   end

   // refill: multiply, then saturating add
   assign base_tok    = hit_ff ? hit_tok_ff : cap;
   assign base_ref    = hit_ff ? hit_ref_ff : now_ff;
   assign mul_elapsed = now_ff - base_ref;
   assign sum         = {33'd0, tok_ff} + {1'b0, prod_ff};

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= {32'd0, mul_elapsed} * {32'd0, rate_ff};
         tok_ff  <= base_tok;
      end
      if (cmd.sum) begin
         bal_ff <= (sum < {33'd0, cap}) ? sum[31:0] : cap;
      end
   end

   assign need  = {wanted_ff, 16'd0};
   assign grant = bal_ff >= need;

   // write-back and valid bookkeeping
   always_comb begin
      wr_en            = 1'b0;
      wr_idx           = hit_idx_ff;
      wr_rec           = '{addr: key_ff, tokens: cap, refill_ms: now_ff, access_ms: now_ff};
      valid_in         = valid_ff;
      count_in         = count_ff;
      res_allowed_in   = 1'b0;
      res_full_in      = 1'b0;
      res_remaining_in = '0;
      if (idle_hit) begin
         valid_in[chk_idx_ff] = 1'b0;
         count_in             = count_ff - CW'(1);
      end
      if (cmd.write) begin
         priority case (op_ff)
            pctbl_pkg::OP_REQUEST: begin
               if (present_ff) begin
                  if (hit_ff || free_ff) begin
                     wr_en          = 1'b1;
                     wr_idx         = hit_ff ? hit_idx_ff : free_idx_ff;
                     wr_rec.tokens  = grant ? bal_ff - need : bal_ff;
                     res_allowed_in = grant;
                     if (!hit_ff) begin
                        valid_in[free_idx_ff] = 1'b1;
                        count_in              = count_ff + CW'(1);
                     end
                  end else begin
                     res_full_in = 1'b1;
                  end
               end
            end
            pctbl_pkg::OP_QUERY: begin
               if (present_ff) begin
                  if (hit_ff) begin
                     wr_en            = 1'b1;
                     wr_rec.tokens    = hit_tok_ff;
                     wr_rec.refill_ms = hit_ref_ff;
                     res_remaining_in = bal_ff;
                  end else begin
                     res_remaining_in = cap;
                  end
               end
            end
            pctbl_pkg::OP_RESET: begin
               wr_en = present_ff && hit_ff;
            end
            pctbl_pkg::OP_CLEAR: begin
               valid_in = '0;
               count_in = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         res_allowed_ff   <= res_allowed_in;
         res_full_ff      <= res_full_in;
         res_remaining_ff <= res_remaining_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_allowed_ff   <= res_allowed_ff;
         rsp_full_ff      <= res_full_ff;
         rsp_remaining_ff <= res_remaining_ff;
         rsp_count_ff     <= count_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_allowed       = rsp_allowed_ff;
   assign rsp_table_full    = rsp_full_ff;
   assign rsp_remaining_q16 = rsp_remaining_ff;
   assign rsp_tracked_count = rsp_count_ff;

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      count_ff == CW'($countones(valid_ff)))
      else $error("entry count differs from valid bits");

   // hit flags are only fresh for ops that ran a scan
   a_hit_still_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.write && status.need_scan && hit_ff && op_ff != pctbl_pkg::OP_CLEANUP)
      |-> valid_ff[hit_idx_ff])
      else $error("write-back to an entry that is not valid");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !(rsp_valid_ff && rsp_stall))
      else $error("result overwritten while stalled");

endmodule

// File: rtl/per_client_token_bucket_limiter.sv
// Sequence: for a request or query with an address: start, table scan, drain, multiply,
// add, write-back, result load; reset and cleanup skip the multiply and add; ops
// that skip the scan go through start, write-back and result load only.
// Throughput: one item at a time, set by the one-entry-per-cycle table scan port; the
// next transfer is taken the cycle after the result loads; result stall delays the load.
// Reset: synchronous active high; clears valid bits, count, FSM and config to defaults.
// Depends on pctbl_pkg, pctbl_ctrl, pctbl_datapath.
`timescale 1ns / 1ps

module per_client_token_bucket_limiter (
   input  logic                        clock,
   input  logic                        reset,
   // configuration writes
   input  logic                        csr_write_enable,
   input  logic                        csr_index,
   input  logic [31:0]                 csr_write_data,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [2:0]                  req_op,
   input  logic [31:0]                 req_client_addr,
   input  logic                        req_addr_present,
   input  logic [15:0]                 req_tokens_wanted,
   input  logic [31:0]                 req_now_ms,
   input  logic [22:0]                 req_idle_limit_s,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_allowed,
   output logic [31:0]                 rsp_remaining_q16,
   output logic [pctbl_pkg::CNT_W-1:0] rsp_tracked_count,
   output logic                        rsp_table_full
);

   // Controller steps the datapath through one item; the datapath reports
   // scan progress and whether the result register can take a new transfer.
   pctbl_pkg::cmd_type    cmd;
   pctbl_pkg::status_type status;

   pctbl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pctbl_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_op            (req_op),
      .req_client_addr   (req_client_addr),
      .req_addr_present  (req_addr_present),
      .req_tokens_wanted (req_tokens_wanted),
      .req_now_ms        (req_now_ms),
      .req_idle_limit_s  (req_idle_limit_s),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_allowed       (rsp_allowed),
      .rsp_remaining_q16 (rsp_remaining_q16),
      .rsp_tracked_count (rsp_tracked_count),
      .rsp_table_full    (rsp_table_full),
      .cmd               (cmd),
      .status            (status)
   );

endmodule
